// ----- design/crpp_pkg.sv -----
package crpp_pkg;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_SENT = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_RESET = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CFG_RESET_CODE    = 3'd0,
    CFG_FAST_CODE     = 3'd1,
    CFG_GYRO_CODE     = 3'd2,
    CFG_ACCEL_CODE    = 3'd3,
    CFG_VARIABLE_CODE = 3'd4,
    CFG_FULL_CODE     = 3'd5,
    CFG_QUERY_CODE    = 3'd6,
    CFG_REPLY_CODES   = 3'd7
  } cfg_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FAST  = 3'd1,
    PH_GYRO  = 3'd2,
    PH_ACCEL = 3'd3,
    PH_FULL  = 3'd4,
    PH_MASK  = 3'd5,
    PH_VAR   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_EMIT  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    BANK_A  = 2'd0,
    BANK_B0 = 2'd1,
    BANK_B1 = 2'd2,
    BANK_B2 = 2'd3
  } bank_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } out_item_t;

  typedef struct packed {
    op_e        op;
    logic       rep;
    logic [7:0] addr;
    logic [7:0] data;
    kind_e      kind;
  } op_t;

  typedef struct packed {
    bank_e      bank;
    logic [7:0] off;
  } loc_t;

  localparam logic [7:0] FAST_BASE    = 8'd2;
  localparam logic [7:0] ACCEL_BASE   = 8'd13;
  localparam logic [7:0] GYRO_BASE    = 8'd19;
  localparam logic [5:0] FAST_LEN     = 6'd10;
  localparam logic [5:0] FULL_LEN     = 6'd47;
  localparam logic [5:0] VEC_LEN      = 6'd6;
  localparam logic [2:0] NUM_SECTIONS = 3'd5;
  localparam logic [2:0] FIRST_IMU    = 3'd3;
  localparam int unsigned B_DEPTH     = 12;
  localparam int unsigned B_AW        = 4;
  localparam int unsigned COPY_BYTES  = 36;

  function automatic logic [7:0] sec_start(logic [2:0] s);
    logic [7:0] r;
    case (s)
      3'd0:    r = 8'd2;
      3'd1:    r = 8'd6;
      3'd2:    r = 8'd9;
      3'd3:    r = 8'd13;
      default: r = 8'd19;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] sec_len(logic [2:0] s);
    logic [5:0] r;
    case (s)
      3'd0:    r = 6'd4;
      3'd1:    r = 6'd3;
      3'd2:    r = 6'd3;
      default: r = 6'd6;
    endcase
    return r;
  endfunction

  // bytes 13..48 live in three twelve-byte banks so one write can hit all copies
  function automatic loc_t map_addr(logic [7:0] a);
    loc_t r;
    if (a < 8'd13) begin
      r.bank = BANK_A;
      r.off  = a;
    end else if (a < 8'd25) begin
      r.bank = BANK_B0;
      r.off  = a - 8'd13;
    end else if (a < 8'd37) begin
      r.bank = BANK_B1;
      r.off  = a - 8'd25;
    end else if (a < 8'd49) begin
      r.bank = BANK_B2;
      r.off  = a - 8'd37;
    end else begin
      r.bank = BANK_A;
      r.off  = a - 8'd36;
    end
    return r;
  endfunction

endpackage

// ----- design/crpp_fifo.sv -----
module crpp_fifo
  import crpp_pkg::*;
#(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  input  logic pop_i,
  output T     data_o,
  output logic full_o,
  output logic afull_o,
  output logic empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d;
  logic [PW-1:0]   rptr_q, rptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign afull_o = (cnt_q >= CW'(DEPTH - 1));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- design/crpp_front.sv -----
module crpp_front
  import crpp_pkg::*;
#(
  parameter int unsigned REPORT_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  in_item_t    item_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        op_valid_o,
  output op_t         op_o
);

  logic [7:0]  reset_code_q, fast_code_q, gyro_code_q, accel_code_q;
  logic [7:0]  variable_code_q, full_code_q, query_code_q;
  logic [15:0] reply_codes_q;

  phase_e     phase_q, phase_d;
  logic [5:0] cnt_q, cnt_d;
  logic [4:0] mask_q, mask_d;
  logic [2:0] sec_q, sec_d;
  logic       ready_q, ready_d;
  logic [5:0] cnt_inc;
  logic [2:0] nxt_sec;

  function automatic logic [2:0] first_sec(logic [4:0] m, logic [2:0] from);
    logic [2:0] r;
    r = NUM_SECTIONS;
    for (int k = 4; k >= 0; k--) begin
      if (3'(k) >= from && m[k]) begin
        r = 3'(k);
      end
    end
    return r;
  endfunction

  assign cnt_inc = cnt_q + 6'd1;

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    mask_d     = mask_q;
    sec_d      = sec_q;
    ready_d    = ready_q;
    nxt_sec    = NUM_SECTIONS;
    op_valid_o = 1'b0;
    op_o.op    = OP_EMIT;
    op_o.rep   = 1'b0;
    op_o.addr  = '0;
    op_o.data  = item_i.rx_byte;
    op_o.kind  = KIND_TX;
    if (accept_i) begin
      case (item_i.command)
        CMD_BYTE: begin
          case (phase_q)
            PH_IDLE: begin
              cnt_d = '0;
              if (item_i.rx_byte == reset_code_q) begin
                op_valid_o = 1'b1;
                op_o.kind  = KIND_RESET;
                op_o.data  = '0;
              end else if (item_i.rx_byte == fast_code_q) begin
                phase_d = PH_FAST;
              end else if (item_i.rx_byte == gyro_code_q) begin
                phase_d = PH_GYRO;
              end else if (item_i.rx_byte == accel_code_q) begin
                phase_d = PH_ACCEL;
              end else if (item_i.rx_byte == variable_code_q) begin
                phase_d = PH_MASK;
              end else if (item_i.rx_byte == full_code_q) begin
                phase_d = PH_FULL;
              end else if (item_i.rx_byte == query_code_q) begin
                op_valid_o = 1'b1;
                op_o.data  = ready_q ? reply_codes_q[7:0] : reply_codes_q[15:8];
              end
            end
            PH_FAST, PH_FULL: begin
              op_valid_o = 1'b1;
              op_o.op    = OP_WRITE;
              op_o.addr  = FAST_BASE + {2'b00, cnt_q};
              cnt_d      = cnt_inc;
              if (cnt_inc >= ((phase_q == PH_FAST) ? FAST_LEN : FULL_LEN)) begin
                ready_d = 1'b0;
                phase_d = PH_IDLE;
                cnt_d   = '0;
              end
            end
            PH_GYRO, PH_ACCEL: begin
              op_valid_o = 1'b1;
              op_o.op    = OP_WRITE;
              op_o.rep   = (phase_q == PH_GYRO);
              op_o.addr  = ((phase_q == PH_GYRO) ? GYRO_BASE : ACCEL_BASE) + {2'b00, cnt_q};
              cnt_d      = cnt_inc;
              if (cnt_inc >= VEC_LEN) begin
                ready_d = 1'b0;
                phase_d = PH_IDLE;
                cnt_d   = '0;
              end
            end
            PH_MASK: begin
              mask_d  = item_i.rx_byte[4:0];
              nxt_sec = first_sec(item_i.rx_byte[4:0], 3'd0);
              sec_d   = nxt_sec;
              cnt_d   = '0;
              if (nxt_sec >= NUM_SECTIONS) begin
                ready_d = 1'b0;
                phase_d = PH_IDLE;
              end else begin
                phase_d = PH_VAR;
              end
            end
            PH_VAR: begin
              if (sec_q >= NUM_SECTIONS) begin
                ready_d = 1'b0;
                phase_d = PH_IDLE;
                cnt_d   = '0;
              end else begin
                op_valid_o = 1'b1;
                op_o.op    = OP_WRITE;
                op_o.rep   = (sec_q >= FIRST_IMU);
                op_o.addr  = sec_start(sec_q) + {2'b00, cnt_q};
                cnt_d      = cnt_inc;
                if (cnt_inc >= sec_len(sec_q)) begin
                  nxt_sec = first_sec(mask_q, sec_q + 3'd1);
                  sec_d   = nxt_sec;
                  cnt_d   = '0;
                  if (nxt_sec >= NUM_SECTIONS) begin
                    ready_d = 1'b0;
                    phase_d = PH_IDLE;
                  end
                end
              end
            end
            default: begin
              phase_d = PH_IDLE;
              cnt_d   = '0;
            end
          endcase
        end
        CMD_SENT: begin
          ready_d = 1'b1;
          if (!ready_q) begin
            op_valid_o = 1'b1;
            op_o.data  = reply_codes_q[7:0];
          end
        end
        CMD_READ: begin
          op_valid_o = 1'b1;
          op_o.kind  = KIND_READ;
          if (9'(item_i.read_index) < 9'(REPORT_BYTES)) begin
            op_o.op   = OP_READ;
            op_o.addr = {2'b00, item_i.read_index};
          end else begin
            op_o.data = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      mask_q  <= '0;
      sec_q   <= '0;
      ready_q <= 1'b1;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      mask_q  <= mask_d;
      sec_q   <= sec_d;
      ready_q <= ready_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_code_q    <= 8'd0;
      fast_code_q     <= 8'd1;
      gyro_code_q     <= 8'd2;
      accel_code_q    <= 8'd3;
      variable_code_q <= 8'd4;
      full_code_q     <= 8'd5;
      query_code_q    <= 8'd6;
      reply_codes_q   <= 16'h0100;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_RESET_CODE:    reset_code_q    <= cfg_wdata_i[7:0];
        CFG_FAST_CODE:     fast_code_q     <= cfg_wdata_i[7:0];
        CFG_GYRO_CODE:     gyro_code_q     <= cfg_wdata_i[7:0];
        CFG_ACCEL_CODE:    accel_code_q    <= cfg_wdata_i[7:0];
        CFG_VARIABLE_CODE: variable_code_q <= cfg_wdata_i[7:0];
        CFG_FULL_CODE:     full_code_q     <= cfg_wdata_i[7:0];
        CFG_QUERY_CODE:    query_code_q    <= cfg_wdata_i[7:0];
        CFG_REPLY_CODES:   reply_codes_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- design/crpp_store.sv -----
module crpp_store
  import crpp_pkg::*;
#(
  parameter int unsigned REPORT_BYTES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      op_valid_i,
  input  op_t       op_i,
  output logic      op_pop_o,
  input  logic      res_full_i,
  input  logic      res_afull_i,
  output logic      res_push_o,
  output out_item_t res_o
);

  localparam int unsigned A_DEPTH = REPORT_BYTES - COPY_BYTES;
  localparam int unsigned A_AW    = $clog2(A_DEPTH);

  logic [7:0]         mem_a [A_DEPTH];
  logic [A_DEPTH-1:0] vld_a_q;
  logic [7:0]         rd_a_q;
  logic               rdv_a_q;
  logic [7:0]         rd_b_q [3];
  logic               rdv_b_q [3];

  loc_t  loc;
  logic  room, wr, rd;

  logic       s2_valid_q;
  logic       s2_read_q;
  kind_e      s2_kind_q;
  logic [7:0] s2_val_q;
  bank_e      s2_bank_q;
  logic [7:0] rd_val;

  // hold back result-producing ops unless a result slot is reserved
  assign room     = s2_valid_q ? !res_afull_i : !res_full_i;
  assign op_pop_o = op_valid_i && ((op_i.op == OP_WRITE) || room);
  assign wr       = op_pop_o && (op_i.op == OP_WRITE);
  assign rd       = op_pop_o && (op_i.op == OP_READ);
  assign loc      = map_addr(op_i.addr);

  always_ff @(posedge clk_i) begin
    if (wr && loc.bank == BANK_A) begin
      mem_a[loc.off[A_AW-1:0]] <= op_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd && loc.bank == BANK_A) begin
      rd_a_q <= mem_a[loc.off[A_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= '0;
      rdv_a_q <= 1'b0;
    end else begin
      if (wr && loc.bank == BANK_A) begin
        vld_a_q[loc.off[A_AW-1:0]] <= 1'b1;
      end
      if (rd && loc.bank == BANK_A) begin
        rdv_a_q <= vld_a_q[loc.off[A_AW-1:0]];
      end
    end
  end

  for (genvar b = 0; b < 3; b++) begin : g_bank
    logic [7:0]         mem_b [B_DEPTH];
    logic [B_DEPTH-1:0] vld_b_q;
    logic               sel;
    logic               we;

    assign sel = (loc.bank == bank_e'(b + 1));
    assign we  = wr && (sel || op_i.rep);

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem_b[loc.off[B_AW-1:0]] <= op_i.data;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rd && sel) begin
        rd_b_q[b] <= mem_b[loc.off[B_AW-1:0]];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_b_q    <= '0;
        rdv_b_q[b] <= 1'b0;
      end else begin
        if (we) begin
          vld_b_q[loc.off[B_AW-1:0]] <= 1'b1;
        end
        if (rd && sel) begin
          rdv_b_q[b] <= vld_b_q[loc.off[B_AW-1:0]];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= op_pop_o && (op_i.op != OP_WRITE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      s2_read_q <= (op_i.op == OP_READ);
      s2_kind_q <= op_i.kind;
      s2_val_q  <= op_i.data;
      s2_bank_q <= loc.bank;
    end
  end

  always_comb begin
    case (s2_bank_q)
      BANK_A:  rd_val = rdv_a_q ? rd_a_q : '0;
      BANK_B0: rd_val = rdv_b_q[0] ? rd_b_q[0] : '0;
      BANK_B1: rd_val = rdv_b_q[1] ? rd_b_q[1] : '0;
      BANK_B2: rd_val = rdv_b_q[2] ? rd_b_q[2] : '0;
      default: rd_val = '0;
    endcase
  end

  assign res_push_o  = s2_valid_q;
  assign res_o.kind  = s2_kind_q;
  assign res_o.value = s2_read_q ? rd_val : s2_val_q;

endmodule

// ----- design/controller_report_packet_parser.sv -----
// Controller report packet parser.
// Input channel: drive item_i and raise push; the item transfers on a clock
// edge where push is high and full is low. An item is a received serial byte,
// a report-sent event or a report byte read.
// Result channel: while empty is low, result_o holds the oldest result; raise
// pop to take it. Results are transmit bytes, reset requests and read data.
// Configuration: cfg_we_i writes cfg_wdata_i into the register at cfg_idx_i;
// write only while the block is idle.
// Throughput: one item per cycle while full is low, set by the parser in the front part and the
// single write port of each store bank (gyro copies land in parallel banks).
// Path: each result passes the op queue, the store's output register and the result queue.
// Reset: the report store reads as zero, the ready flag is set, the parser
// waits for a type byte and the registers return to their default codes.
// Stall: when pop is held low the result queue fills, then the op queue
// between parser and store fills and full rises; nothing is dropped.
module controller_report_packet_parser
  import crpp_pkg::*;
#(
  parameter int unsigned REPORT_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    item_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   result_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned OPQ_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 4;

  logic      accept;
  logic      fe_valid;
  op_t       fe_op;
  op_t       q_op;
  logic      q_empty;
  logic      q_pop;
  logic      res_push, res_full, res_afull;
  out_item_t res_item;

  assign accept = push && !full;

  crpp_front #(
    .REPORT_BYTES(REPORT_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .op_valid_o (fe_valid),
    .op_o       (fe_op)
  );

  crpp_fifo #(
    .T    (op_t),
    .DEPTH(OPQ_DEPTH)
  ) u_opq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fe_valid),
    .data_i (fe_op),
    .pop_i  (q_pop),
    .data_o (q_op),
    .full_o (full),
    .afull_o(),
    .empty_o(q_empty)
  );

  crpp_store #(
    .REPORT_BYTES(REPORT_BYTES)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (!q_empty),
    .op_i       (q_op),
    .op_pop_o   (q_pop),
    .res_full_i (res_full),
    .res_afull_i(res_afull),
    .res_push_o (res_push),
    .res_o      (res_item)
  );

  crpp_fifo #(
    .T    (out_item_t),
    .DEPTH(RES_DEPTH)
  ) u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_item),
    .pop_i  (pop),
    .data_o (result_o),
    .full_o (res_full),
    .afull_o(res_afull),
    .empty_o(empty)
  );

endmodule
